@@ design/mcra_pkg.sv @@
package mcra_pkg;

   localparam int NUM_CH       = 3;
   localparam int SAMPLE_W     = 16;
   localparam int STATUS_W     = 2;
   localparam int WINDOW_DEPTH = 8;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FAULT = 2'd2;

   localparam logic [1:0] FAILED_NONE = 2'd3;

   typedef struct packed {
      logic                                 stale;
      logic                                 fault;
      logic [1:0]                           nch;
      logic [NUM_CH-1:0][SAMPLE_W-1:0]      sample;
   } cmd_type;

endpackage

@@ design/mcra_channels.sv @@
interface mcra_req_if;
   logic                          valid;
   logic                          ready;
   logic [mcra_pkg::SAMPLE_W-1:0] sample_ch0;
   logic [mcra_pkg::SAMPLE_W-1:0] sample_ch1;
   logic [mcra_pkg::SAMPLE_W-1:0] sample_ch2;
   logic [1:0]                    failed_channel;

   modport source (output valid, sample_ch0, sample_ch1, sample_ch2, failed_channel,
                   input ready);
   modport sink   (input valid, sample_ch0, sample_ch1, sample_ch2, failed_channel,
                   output ready);
endinterface

interface mcra_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mcra_pkg::STATUS_W-1:0] status;
   logic [mcra_pkg::SAMPLE_W-1:0] average_ch0;
   logic [mcra_pkg::SAMPLE_W-1:0] average_ch1;
   logic [mcra_pkg::SAMPLE_W-1:0] average_ch2;
   logic [mcra_pkg::SAMPLE_W-1:0] last_raw_ch0;
   logic [mcra_pkg::SAMPLE_W-1:0] last_raw_ch1;
   logic [mcra_pkg::SAMPLE_W-1:0] last_raw_ch2;
   logic [mcra_pkg::NUM_CH-1:0]   valid_mask;
   logic                          fault_flag;

   modport source (output valid, status, average_ch0, average_ch1, average_ch2,
                   last_raw_ch0, last_raw_ch1, last_raw_ch2, valid_mask, fault_flag,
                   input ready);
   modport sink   (input valid, status, average_ch0, average_ch1, average_ch2,
                   last_raw_ch0, last_raw_ch1, last_raw_ch2, valid_mask, fault_flag,
                   output ready);
endinterface

interface mcra_csr_if;
   logic valid;
   logic ready;
   logic device_ready;

   modport source (output valid, device_ready, input ready);
   modport sink   (input valid, device_ready, output ready);
endinterface

@@ design/mcra_front.sv @@
module mcra_front (
   input  logic                  clock,
   input  logic                  reset,
   mcra_req_if.sink              req_ch,
   mcra_csr_if.sink              csr_ch,
   output logic                  push_valid,
   input  logic                  push_ready,
   output mcra_pkg::cmd_type     push_cmd
);

   logic dev_ready_ff;
   logic dev_ready_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      dev_ready_in = dev_ready_ff;
      if (csr_ch.valid) begin
         dev_ready_in = csr_ch.device_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ready_ff <= 1'b0;
      end else begin
         dev_ready_ff <= dev_ready_in;
      end
   end

   // classify: stale, or number of channels to update and whether a fault ends the poll
   always_comb begin
      push_cmd.stale     = !dev_ready_ff;
      push_cmd.fault     = (req_ch.failed_channel != mcra_pkg::FAILED_NONE);
      push_cmd.nch       = push_cmd.fault ? req_ch.failed_channel : 2'(mcra_pkg::NUM_CH);
      push_cmd.sample[0] = req_ch.sample_ch0;
      push_cmd.sample[1] = req_ch.sample_ch1;
      push_cmd.sample[2] = req_ch.sample_ch2;
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule

@@ design/mcra_queue.sv @@
module mcra_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  mcra_pkg::cmd_type     push_cmd,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output mcra_pkg::cmd_type     pop_cmd
);

   localparam int PW = $clog2(mcra_pkg::QUEUE_DEPTH);
   localparam int NW = $clog2(mcra_pkg::QUEUE_DEPTH + 1);
   localparam logic [NW-1:0] FULL_LEVEL = NW'(mcra_pkg::QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_PTR   = PW'(mcra_pkg::QUEUE_DEPTH - 1);

   mcra_pkg::cmd_type entry_ff [mcra_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wptr_ff, wptr_in;
   logic [PW-1:0]     rptr_ff, rptr_in;
   logic [NW-1:0]     level_ff, level_in;
   logic              do_push, do_pop;

   assign push_ready = (level_ff != FULL_LEVEL);
   assign pop_valid  = (level_ff != '0);
   assign pop_cmd    = entry_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      level_in = level_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == LAST_PTR) ? '0 : PW'(wptr_ff + 1'b1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == LAST_PTR) ? '0 : PW'(rptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         level_in = NW'(level_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         level_in = NW'(level_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         level_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/mcra_div.sv @@
module mcra_div #(
   parameter int DividendW = 19,
   parameter int DivisorW  = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [DividendW-1:0]             dividend,
   input  logic [DivisorW-1:0]              divisor,
   output logic                             done,
   output logic [mcra_pkg::SAMPLE_W-1:0]    quotient
);

   localparam int KW = $clog2(DividendW + 1);

   logic [DividendW-1:0] dvd_ff, dvd_in;
   logic [DivisorW-1:0]  dvs_ff, dvs_in;
   logic [DivisorW-1:0]  rem_ff, rem_in;
   logic [KW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DivisorW:0]    trial;
   logic                 fits;

   assign trial = {rem_ff, dvd_ff[DividendW-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = KW'(DividendW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DivisorW'(trial - {1'b0, dvs_ff}) : trial[DivisorW-1:0];
         dvd_in = {dvd_ff[DividendW-2:0], fits};
         cnt_in = KW'(cnt_ff - 1'b1);
         if (cnt_ff == KW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff[mcra_pkg::SAMPLE_W-1:0];

endmodule

@@ design/mcra_back.sv @@
module mcra_back #(
   parameter int Depth = mcra_pkg::WINDOW_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  mcra_pkg::cmd_type     cmd,
   mcra_rsp_if.source            rsp_ch
);

   localparam int NCH  = mcra_pkg::NUM_CH;
   localparam int SMW  = mcra_pkg::SAMPLE_W;
   localparam int CW   = $clog2(Depth + 1);
   localparam int SW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int EN   = NCH * Depth;
   localparam int AW   = $clog2(EN);
   localparam int SUMW = SMW + CW;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(Depth);
   localparam logic [SW-1:0] LAST_SLOT = SW'(Depth - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_WRITE, ST_SUM, ST_DIV_START, ST_DIV_WAIT, ST_FINISH, ST_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   mcra_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [1:0]                        ch_ff, ch_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   logic                              pend_ff, pend_in;
   logic [SUMW-1:0]                   sum_ff, sum_in;
   logic [SW-1:0]                     slot_ff, slot_in;
   logic [CW-1:0]                     cnt_ff [NCH];
   logic [CW-1:0]                     cnt_in [NCH];
   logic [SMW-1:0]                    raw_ff [NCH];
   logic [SMW-1:0]                    raw_in [NCH];
   logic [SMW-1:0]                    avg_ff [NCH];
   logic [SMW-1:0]                    avg_in [NCH];
   logic [NCH-1:0]                    chv_ff, chv_in;
   logic                              fault_ff, fault_in;
   logic [mcra_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [EN-1:0]                     hvld_ff, hvld_in;
   logic                              rdok_ff;
   logic [SMW-1:0]                    rdata_ff;
   logic [SMW-1:0]                    hist_mem [EN];

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_load;
   logic [mcra_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [SMW-1:0]                    rsp_avg_ff [NCH];
   logic [SMW-1:0]                    rsp_raw_ff [NCH];
   logic [NCH-1:0]                    rsp_mask_ff;
   logic                              rsp_fault_ff;

   logic [SMW-1:0]                    cur_raw;
   logic [CW-1:0]                     cur_cnt;
   logic [AW-1:0]                     base_addr, wr_addr, rd_addr;
   logic                              mem_we;
   logic                              div_start, div_done;
   logic [SMW-1:0]                    div_quot;

   assign cur_raw   = cmd_ff.sample[ch_ff];
   assign cur_cnt   = cnt_ff[ch_ff];
   assign base_addr = AW'(AW'(ch_ff) * AW'(Depth));
   assign wr_addr   = AW'(base_addr + AW'(slot_ff));
   assign rd_addr   = AW'(base_addr + AW'(idx_ff));
   assign mem_we    = (state_ff == ST_WRITE);

   mcra_div #(
      .DividendW (SUMW),
      .DivisorW  (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cur_cnt),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ch_in        = ch_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      sum_in       = sum_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      raw_in       = raw_ff;
      avg_in       = avg_ff;
      chv_in       = chv_ff;
      fault_in     = fault_ff;
      status_in    = status_ff;
      hvld_in      = hvld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_load     = 1'b0;
      cmd_ready    = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd;
               ch_in  = '0;
               if (cmd.stale) begin
                  status_in = mcra_pkg::STATUS_STALE;
                  state_in  = ST_EMIT;
               end else if (cmd.nch == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            cnt_in[ch_ff]    = (cur_cnt == DEPTH_CNT) ? cur_cnt : CW'(cur_cnt + 1'b1);
            raw_in[ch_ff]    = cur_raw;
            chv_in[ch_ff]    = 1'b1;
            hvld_in[wr_addr] = 1'b1;
            idx_in           = '0;
            pend_in          = 1'b0;
            sum_in           = '0;
            state_in         = ST_SUM;
         end
         ST_SUM: begin
            // one read issued per cycle, data accumulated in the next cycle
            pend_in = (idx_ff != cur_cnt);
            if (idx_ff != cur_cnt) begin
               idx_in = CW'(idx_ff + 1'b1);
            end
            if (pend_ff && rdok_ff) begin
               sum_in = SUMW'(sum_ff + SUMW'(rdata_ff));
            end
            if (idx_ff == cur_cnt && !pend_ff) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               avg_in[ch_ff] = div_quot;
               if (2'(ch_ff + 1'b1) == cmd_ff.nch) begin
                  state_in = ST_FINISH;
               end else begin
                  ch_in    = 2'(ch_ff + 1'b1);
                  state_in = ST_WRITE;
               end
            end
         end
         ST_FINISH: begin
            if (cmd_ff.fault) begin
               fault_in  = 1'b1;
               status_in = mcra_pkg::STATUS_FAULT;
            end else begin
               fault_in  = 1'b0;
               slot_in   = (slot_ff == LAST_SLOT) ? '0 : SW'(slot_ff + 1'b1);
               status_in = mcra_pkg::STATUS_OK;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         slot_ff      <= '0;
         chv_ff       <= '0;
         fault_ff     <= 1'b0;
         hvld_ff      <= '0;
         rdok_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NCH; k++) begin
            cnt_ff[k] <= '0;
            raw_ff[k] <= '0;
            avg_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         slot_ff      <= slot_in;
         chv_ff       <= chv_in;
         fault_ff     <= fault_in;
         hvld_ff      <= hvld_in;
         rdok_ff      <= hvld_ff[rd_addr];
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         raw_ff       <= raw_in;
         avg_ff       <= avg_in;
      end
      cmd_ff    <= cmd_in;
      sum_ff    <= sum_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_avg_ff    <= avg_ff;
         rsp_raw_ff    <= raw_ff;
         rsp_mask_ff   <= chv_ff;
         rsp_fault_ff  <= fault_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wr_addr] <= cur_raw;
      end
      rdata_ff <= hist_mem[rd_addr];
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.average_ch0  = rsp_avg_ff[0];
   assign rsp_ch.average_ch1  = rsp_avg_ff[1];
   assign rsp_ch.average_ch2  = rsp_avg_ff[2];
   assign rsp_ch.last_raw_ch0 = rsp_raw_ff[0];
   assign rsp_ch.last_raw_ch1 = rsp_raw_ff[1];
   assign rsp_ch.last_raw_ch2 = rsp_raw_ff[2];
   assign rsp_ch.valid_mask   = rsp_mask_ff;
   assign rsp_ch.fault_flag   = rsp_fault_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= DEPTH_CNT && cnt_ff[1] <= DEPTH_CNT && cnt_ff[2] <= DEPTH_CNT)
      else $error("fill count above window depth");

   a_write_ch: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> ch_ff < cmd_ff.nch && !cmd_ff.stale)
      else $error("channel update past failing channel");

   a_sum_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> idx_ff <= cur_cnt && cur_cnt != '0)
      else $error("sum index out of window");

   a_slot_adv: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && !cmd_ff.fault |=>
         !fault_ff && slot_ff == (($past(slot_ff) == LAST_SLOT) ? '0
                                  : SW'($past(slot_ff) + 1'b1)))
      else $error("write slot did not advance on clean poll");
`endif

endmodule

@@ design/multi_channel_rolling_average_top.sv @@
// Three-channel rolling average with warm-up.
// req_ch: one word per poll, three 16-bit samples and the failed channel (3 = none).
// rsp_ch: one word per poll, status, stored averages, last raw samples, valid mask
//   and fault flag after that poll.
// csr_ch: writes device_ready; always ready. Write it only while the block is idle.
// Polls enter a two-word queue; while a result waits, the back end holds one more
//   word and the queue two, so three words are taken before req_ch.ready drops.
// Each updated channel takes one history write, one memory read per filled entry,
//   then a one-bit-per-cycle divider over SUM_W = 16 + clog2(depth+1) bits. The
//   history memory's single read port and the serial divider set the poll's length.
// Reset clears history (per-entry valid bits), counts, slot, stored values and
//   device_ready; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the back end then
//   waits and the queue fills, after which req_ch.ready drops.
module multi_channel_rolling_average_top #(
   parameter int WindowDepth = mcra_pkg::WINDOW_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   mcra_req_if.sink      req_ch,
   mcra_rsp_if.source    rsp_ch,
   mcra_csr_if.sink      csr_ch
);

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   mcra_pkg::cmd_type push_cmd, pop_cmd;

   mcra_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   mcra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   mcra_back #(
      .Depth (WindowDepth)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule
